// ----- rtl/sfpb_pkg.sv -----
`timescale 1ns / 1ps

package sfpb_pkg;

    // Protocol command codes.
    localparam logic [7:0] CMD_NOP         = 8'h00;
    localparam logic [7:0] CMD_Q_IFACE     = 8'h01;
    localparam logic [7:0] CMD_Q_CMDMAP    = 8'h02;
    localparam logic [7:0] CMD_Q_PGMNAME   = 8'h03;
    localparam logic [7:0] CMD_Q_SERBUF    = 8'h04;
    localparam logic [7:0] CMD_Q_BUSTYPE   = 8'h05;
    localparam logic [7:0] CMD_Q_WRNMAXLEN = 8'h08;
    localparam logic [7:0] CMD_SYNCNOP     = 8'h10;
    localparam logic [7:0] CMD_Q_RDNMAXLEN = 8'h11;
    localparam logic [7:0] CMD_S_BUSTYPE   = 8'h12;
    localparam logic [7:0] CMD_O_SPIOP     = 8'h13;

    localparam logic [7:0] ACK_BYTE = 8'h06;
    localparam logic [7:0] NAK_BYTE = 8'h15;

    // Result destinations.
    localparam logic [1:0] DEST_HOST      = 2'd0;
    localparam logic [1:0] DEST_SPI_WRITE = 2'd1;
    localparam logic [1:0] DEST_READ_REQ  = 2'd2;
    localparam logic [1:0] DEST_CS        = 2'd3;

    // Input operation codes.
    localparam logic OP_HOST = 1'b0;
    localparam logic OP_SPI  = 1'b1;

    // Configuration register indexes.
    localparam logic [2:0] CFG_IFACE_VERSION = 3'd0;
    localparam logic [2:0] CFG_SERIAL_BUF    = 3'd1;
    localparam logic [2:0] CFG_MAX_WRITE     = 3'd2;
    localparam logic [2:0] CFG_MAX_READ      = 3'd3;
    localparam logic [2:0] CFG_BUS_FLAG      = 3'd4;

    localparam int SPIOP_HDR = 6;
    localparam int NAME_LEN  = 16;
    localparam int MAP_LEN   = 32;

    // Programmer name, zero padded to sixteen bytes.
    localparam logic [7:0] NAME_BYTES [NAME_LEN] = '{
        8'h57, 8'h69, 8'h78, 8'h65, 8'h6C, 8'h20, 8'h73, 8'h65,
        8'h72, 8'h70, 8'h72, 8'h6F, 8'h67, 8'h00, 8'h00, 8'h00
    };

    typedef struct packed {
        logic [15:0] iface_version;
        logic [15:0] serial_buf_size;
        logic [23:0] max_write_len;
        logic [23:0] max_read_len;
        logic [7:0]  spi_bus_flag;
    } t_cfg;

    typedef struct packed {
        logic [1:0] dest;
        logic [7:0] data;
    } t_res;

    // One queued reply: either a query answer generated byte by byte, or
    // a short explicit list of up to three results.
    typedef struct packed {
        logic           is_query;
        logic [7:0]     cmd;
        logic [5:0]     count;
        t_res [2:0]     ent;
    } t_desc;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic [5:0] query_len(input logic [7:0] cmd);
        logic [5:0] n;
        begin
            case (cmd)
                CMD_NOP:         n = 6'd1;
                CMD_Q_IFACE:     n = 6'd3;
                CMD_Q_CMDMAP:    n = 6'(MAP_LEN + 1);
                CMD_Q_PGMNAME:   n = 6'(NAME_LEN + 1);
                CMD_Q_SERBUF:    n = 6'd3;
                CMD_Q_BUSTYPE:   n = 6'd2;
                CMD_Q_WRNMAXLEN: n = 6'd4;
                CMD_SYNCNOP:     n = 6'd2;
                CMD_Q_RDNMAXLEN: n = 6'd4;
                default:         n = 6'd1;
            endcase
            return n;
        end
    endfunction

    function automatic logic [7:0] pick3(input logic [5:0] idx, input logic [23:0] v);
        logic [7:0] r;
        begin
            case (idx)
                6'd1:    r = v[7:0];
                6'd2:    r = v[15:8];
                6'd3:    r = v[23:16];
                default: r = ACK_BYTE;
            endcase
            return r;
        end
    endfunction

    function automatic logic [7:0] query_byte(input logic [7:0] cmd, input logic [5:0] idx,
                                              input t_cfg cfg);
        logic [7:0] r;
        logic [3:0] ni;
        begin
            ni = 4'(idx - 6'd1);
            case (cmd)
                CMD_NOP:         r = ACK_BYTE;
                CMD_Q_IFACE:     r = pick3(idx, {8'h00, cfg.iface_version});
                CMD_Q_CMDMAP: begin
                    case (idx)
                        6'd0:    r = ACK_BYTE;
                        6'd1:    r = 8'h3F;
                        6'd2:    r = 8'h01;
                        6'd3:    r = 8'h0F;
                        default: r = 8'h00;
                    endcase
                end
                CMD_Q_PGMNAME:   r = (idx == 6'd0) ? ACK_BYTE : NAME_BYTES[ni];
                CMD_Q_SERBUF:    r = pick3(idx, {8'h00, cfg.serial_buf_size});
                CMD_Q_BUSTYPE:   r = pick3(idx, {16'h0000, cfg.spi_bus_flag});
                CMD_Q_WRNMAXLEN: r = pick3(idx, cfg.max_write_len);
                CMD_SYNCNOP:     r = (idx == 6'd0) ? NAK_BYTE : ACK_BYTE;
                CMD_Q_RDNMAXLEN: r = pick3(idx, cfg.max_read_len);
                default:         r = NAK_BYTE;
            endcase
            return r;
        end
    endfunction

endpackage

// ----- rtl/sfpb_decode.sv -----
`timescale 1ns / 1ps

module sfpb_decode #(
    parameter int LENGTH_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic                 i_op,
    input  logic [7:0]           i_byte,
    input  logic [7:0]           i_bus_flag,
    output logic                 o_push,
    output sfpb_pkg::t_desc      o_desc
);

    localparam int CNT_W = LENGTH_BITS + 1;

    typedef enum logic [2:0] {
        PH_CMD   = 3'b001,
        PH_PARAM = 3'b010,
        PH_READ  = 3'b100
    } t_phase;

    t_phase                 r_phase, n_phase;
    logic [7:0]             r_cmd, n_cmd;
    logic [CNT_W-1:0]       r_bt, n_bt;
    logic [CNT_W-1:0]       r_be, n_be;
    logic [LENGTH_BITS-1:0] r_wc, n_wc;
    logic [LENGTH_BITS-1:0] r_rl, n_rl;

    logic [CNT_W-1:0]       w_bt_inc;
    logic [4:0]             w_sh;
    logic [23:0]            w_shifted;
    logic [LENGTH_BITS-1:0] w_wc_new;
    logic [LENGTH_BITS-1:0] w_rl_new;
    logic [LENGTH_BITS-1:0] w_rl_dec;
    sfpb_pkg::t_desc        w_desc;
    logic                   w_has;

    assign w_bt_inc = r_bt + CNT_W'(1);

    // Byte lane of the little-endian length field being collected.
    always_comb begin
        if (w_bt_inc == CNT_W'(2) || w_bt_inc == CNT_W'(5)) begin
            w_sh = 5'd8;
        end else if (w_bt_inc == CNT_W'(3) || w_bt_inc == CNT_W'(6)) begin
            w_sh = 5'd16;
        end else begin
            w_sh = 5'd0;
        end
    end

    assign w_shifted = {16'h0000, i_byte} << w_sh;
    assign w_wc_new  = r_wc | w_shifted[LENGTH_BITS-1:0];
    assign w_rl_new  = r_rl | w_shifted[LENGTH_BITS-1:0];
    assign w_rl_dec  = r_rl - LENGTH_BITS'(1);

    always_comb begin
        n_phase = r_phase;
        n_cmd   = r_cmd;
        n_bt    = r_bt;
        n_be    = r_be;
        n_wc    = r_wc;
        n_rl    = r_rl;
        w_desc  = '0;
        w_has   = 1'b0;

        if (i_op == sfpb_pkg::OP_SPI) begin
            if (r_phase == PH_READ && r_rl != '0) begin
                w_has               = 1'b1;
                w_desc.ent[0].dest  = sfpb_pkg::DEST_HOST;
                w_desc.ent[0].data  = i_byte;
                n_rl                = w_rl_dec;
                if (w_rl_dec == '0) begin
                    w_desc.ent[1].dest = sfpb_pkg::DEST_CS;
                    w_desc.ent[1].data = 8'h00;
                    w_desc.count       = 6'd2;
                    n_phase            = PH_CMD;
                end else begin
                    w_desc.count = 6'd1;
                end
            end
        end else begin
            case (r_phase)
                PH_READ: begin
                    // Host bytes are dropped while reads are outstanding.
                end
                PH_PARAM: begin
                    n_bt = w_bt_inc;
                    if (r_cmd == sfpb_pkg::CMD_S_BUSTYPE) begin
                        w_has              = 1'b1;
                        w_desc.count       = 6'd1;
                        w_desc.ent[0].dest = sfpb_pkg::DEST_HOST;
                        w_desc.ent[0].data = (i_byte == i_bus_flag) ? sfpb_pkg::ACK_BYTE
                                                                    : sfpb_pkg::NAK_BYTE;
                        n_phase            = PH_CMD;
                    end else if (w_bt_inc <= CNT_W'(sfpb_pkg::SPIOP_HDR)) begin
                        if (w_bt_inc <= CNT_W'(3)) begin
                            n_wc = w_wc_new;
                        end else begin
                            n_rl = w_rl_new;
                        end
                        if (w_bt_inc == CNT_W'(3)) begin
                            n_be = CNT_W'(sfpb_pkg::SPIOP_HDR) + {1'b0, w_wc_new};
                        end
                        if (w_bt_inc == CNT_W'(sfpb_pkg::SPIOP_HDR)) begin
                            w_has              = 1'b1;
                            w_desc.ent[0].dest = sfpb_pkg::DEST_CS;
                            w_desc.ent[0].data = 8'h01;
                            w_desc.count       = 6'd1;
                            // No write bytes: the transfer finishes right away.
                            if (r_be == CNT_W'(sfpb_pkg::SPIOP_HDR)) begin
                                w_desc.count       = 6'd3;
                                w_desc.ent[1].dest = sfpb_pkg::DEST_HOST;
                                w_desc.ent[1].data = sfpb_pkg::ACK_BYTE;
                                if (w_rl_new != '0) begin
                                    w_desc.ent[2].dest = sfpb_pkg::DEST_READ_REQ;
                                    w_desc.ent[2].data = w_rl_new[7:0];
                                    n_phase            = PH_READ;
                                end else begin
                                    w_desc.ent[2].dest = sfpb_pkg::DEST_CS;
                                    w_desc.ent[2].data = 8'h00;
                                    n_phase            = PH_CMD;
                                end
                            end
                        end
                    end else begin
                        w_has              = 1'b1;
                        w_desc.ent[0].dest = sfpb_pkg::DEST_SPI_WRITE;
                        w_desc.ent[0].data = i_byte;
                        w_desc.count       = 6'd1;
                        if (w_bt_inc >= r_be) begin
                            w_desc.count       = 6'd3;
                            w_desc.ent[1].dest = sfpb_pkg::DEST_HOST;
                            w_desc.ent[1].data = sfpb_pkg::ACK_BYTE;
                            if (r_rl != '0) begin
                                w_desc.ent[2].dest = sfpb_pkg::DEST_READ_REQ;
                                w_desc.ent[2].data = r_rl[7:0];
                                n_phase            = PH_READ;
                            end else begin
                                w_desc.ent[2].dest = sfpb_pkg::DEST_CS;
                                w_desc.ent[2].data = 8'h00;
                                n_phase            = PH_CMD;
                            end
                        end
                    end
                end
                default: begin
                    // Waiting for a command byte.
                    n_cmd   = i_byte;
                    n_bt    = '0;
                    n_be    = '0;
                    n_phase = PH_CMD;
                    if (i_byte == sfpb_pkg::CMD_S_BUSTYPE) begin
                        n_be    = CNT_W'(1);
                        n_phase = PH_PARAM;
                    end else if (i_byte == sfpb_pkg::CMD_O_SPIOP) begin
                        n_be    = CNT_W'(sfpb_pkg::SPIOP_HDR);
                        n_wc    = '0;
                        n_rl    = '0;
                        n_phase = PH_PARAM;
                    end else begin
                        w_has           = 1'b1;
                        w_desc.is_query = 1'b1;
                        w_desc.cmd      = i_byte;
                        w_desc.count    = sfpb_pkg::query_len(i_byte);
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_CMD;
            r_cmd   <= '0;
            r_bt    <= '0;
            r_be    <= '0;
            r_wc    <= '0;
            r_rl    <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_cmd   <= n_cmd;
            r_bt    <= n_bt;
            r_be    <= n_be;
            r_wc    <= n_wc;
            r_rl    <= n_rl;
        end
    end

    assign o_push = i_accept && w_has;
    assign o_desc = w_desc;

endmodule

// ----- rtl/sfpb_queue.sv -----
`timescale 1ns / 1ps

module sfpb_queue #(
    parameter int DEPTH = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  sfpb_pkg::t_desc       i_desc,
    input  logic                  i_pop,
    output sfpb_pkg::t_desc       o_head,
    output sfpb_pkg::t_q_status   o_stat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    sfpb_pkg::t_desc  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    assign o_head       = r_mem[r_rd];
    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

// ----- rtl/sfpb_emit.sv -----
`timescale 1ns / 1ps

module sfpb_emit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sfpb_pkg::t_cfg       i_cfg,
    input  sfpb_pkg::t_desc      i_head,
    input  sfpb_pkg::t_q_status  i_stat,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [1:0]           o_dest,
    output logic [7:0]           o_data,
    output logic                 o_last
);

    logic [5:0] r_idx;
    logic       r_valid;
    logic [1:0] r_dest;
    logic [7:0] r_data;
    logic       r_last;

    logic       w_take;
    logic       w_load;
    logic       w_end;
    logic [1:0] w_dest;
    logic [7:0] w_data;

    assign w_take = !r_valid || i_ready;
    assign w_load = w_take && !i_stat.empty;
    assign w_end  = (r_idx == i_head.count - 6'd1);

    always_comb begin
        if (i_head.is_query) begin
            w_dest = sfpb_pkg::DEST_HOST;
            w_data = sfpb_pkg::query_byte(i_head.cmd, r_idx, i_cfg);
        end else begin
            case (r_idx[1:0])
                2'd0: begin
                    w_dest = i_head.ent[0].dest;
                    w_data = i_head.ent[0].data;
                end
                2'd1: begin
                    w_dest = i_head.ent[1].dest;
                    w_data = i_head.ent[1].data;
                end
                default: begin
                    w_dest = i_head.ent[2].dest;
                    w_data = i_head.ent[2].data;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (w_take) begin
            r_valid <= !i_stat.empty;
            if (w_load) begin
                r_idx <= w_end ? 6'd0 : r_idx + 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_dest <= w_dest;
            r_data <= w_data;
            r_last <= w_end;
        end
    end

    assign o_pop   = w_load && w_end;
    assign o_valid = r_valid;
    assign o_dest  = r_dest;
    assign o_data  = r_data;
    assign o_last  = r_last;

endmodule

// ----- rtl/serial_flash_programmer_bridge.sv -----
`timescale 1ns / 1ps

// Serial flash programmer command engine, SPI bus only.
// The slave stream carries one byte per item: tuser says whether it came
// from the host link or is a byte read back from the SPI flash. The master
// stream carries results: tuser gives the destination (host reply, SPI
// write byte, SPI read burst request or chip select level), tdata the byte,
// and tlast marks the final result caused by one input item.
// An input item is decoded in the cycle it is accepted; its results are
// placed as one entry in a short reply queue and leave through a registered
// output stage one result per cycle while the receiver is ready. An item
// with a single result (SPI payload bytes, read-back bytes) sustains one
// item per cycle while the receiver is ready; a query reply leaves byte by
// byte, holding its queue entry until its last byte is loaded, while up to
// QUEUE_DEPTH - 1 further items with results are queued. When the receiver
// stalls, the output holds its result and the queue fills; s_axis_tready
// drops only when the queue is full. Reset (synchronous, active low)
// empties the queue, returns to waiting for a command and restores the
// register defaults. Registers must be written by the user on the plain
// write port only while the block is idle; the block does not enforce it.
module serial_flash_programmer_bridge #(
    parameter int LENGTH_BITS = 8,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] operation

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] payload
    output logic [1:0]  m_axis_tuser,   // [1:0] destination
    output logic        m_axis_tlast    // last
);

    sfpb_pkg::t_cfg      r_cfg;
    sfpb_pkg::t_desc     w_push_desc;
    sfpb_pkg::t_desc     w_head;
    sfpb_pkg::t_q_status w_stat;
    logic                w_accept;
    logic                w_push;
    logic                w_pop;

    // Register file. Writes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.iface_version   <= 16'd1;
            r_cfg.serial_buf_size <= 16'd16;
            r_cfg.max_write_len   <= 24'd200;
            r_cfg.max_read_len    <= 24'd200;
            r_cfg.spi_bus_flag    <= 8'd8;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sfpb_pkg::CFG_IFACE_VERSION: r_cfg.iface_version   <= i_cfg_data[15:0];
                sfpb_pkg::CFG_SERIAL_BUF:    r_cfg.serial_buf_size <= i_cfg_data[15:0];
                sfpb_pkg::CFG_MAX_WRITE:     r_cfg.max_write_len   <= i_cfg_data;
                sfpb_pkg::CFG_MAX_READ:      r_cfg.max_read_len    <= i_cfg_data;
                sfpb_pkg::CFG_BUS_FLAG:      r_cfg.spi_bus_flag    <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // An item is taken whenever the reply queue has a free entry.
    assign s_axis_tready = !w_stat.full;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    sfpb_decode #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_decode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_op       (s_axis_tuser),
        .i_byte     (s_axis_tdata),
        .i_bus_flag (r_cfg.spi_bus_flag),
        .o_push     (w_push),
        .o_desc     (w_push_desc)
    );

    sfpb_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_desc  (w_push_desc),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_stat)
    );

    sfpb_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_head  (w_head),
        .i_stat  (w_stat),
        .o_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_dest  (m_axis_tuser),
        .o_data  (m_axis_tdata),
        .o_last  (m_axis_tlast)
    );

    // A full queue always has a result waiting in the output register.
    a_full_has_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("reply queue full while output register is empty");

    // Results of one item leave without gaps until tlast.
    a_no_gap_in_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |=> m_axis_tvalid)
        else $error("gap inside a multi-result reply");

    // A read burst request always closes the results of its item.
    a_request_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == sfpb_pkg::DEST_READ_REQ |-> m_axis_tlast)
        else $error("read request not marked last");

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;

    localparam int LENGTH_BITS = 8;
    localparam int LEN_MASK    = (1 << LENGTH_BITS) - 1;

    // Cycles to let pass after the last expected result before the
    // configuration is touched or the run ends. Most header bytes of an SPI
    // transfer and ignored bytes produce no result, so the block may still
    // be working on them when the reply queue looks empty.
    localparam int SETTLE_CYCLES = 16;

    // Length of the one long receiver stall that backs up the reply queue.
    localparam int HOLD_CYCLES = 200;

    // Programmer name bytes as the host sees them, zero padded.
    localparam logic [7:0] PGM_NAME [16] = '{
        8'h57, 8'h69, 8'h78, 8'h65, 8'h6C, 8'h20, 8'h73, 8'h65,
        8'h72, 8'h70, 8'h72, 8'h6F, 8'h67, 8'h00, 8'h00, 8'h00
    };

    // All named commands that get a query answer.
    localparam logic [7:0] QUERY_CMDS [9] = '{
        sfpb_pkg::CMD_NOP, sfpb_pkg::CMD_Q_IFACE, sfpb_pkg::CMD_Q_CMDMAP,
        sfpb_pkg::CMD_Q_PGMNAME, sfpb_pkg::CMD_Q_SERBUF, sfpb_pkg::CMD_Q_BUSTYPE,
        sfpb_pkg::CMD_Q_WRNMAXLEN, sfpb_pkg::CMD_SYNCNOP, sfpb_pkg::CMD_Q_RDNMAXLEN
    };

    typedef struct packed {
        logic       op;
        logic [7:0] data;
    } t_host_item;

    typedef struct packed {
        logic [1:0] dest;
        logic [7:0] data;
        logic       last;
    } t_reply;

    typedef enum logic [1:0] {
        WAIT_CMD    = 2'd0,
        TAKE_PARAMS = 2'd1,
        WAIT_READS  = 2'd2
    } t_bridge_phase;

    // Clock, reset and all block inputs start at known values.
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [2:0]  i_cfg_idx     = sfpb_pkg::CFG_IFACE_VERSION;
    logic [23:0] i_cfg_data    = 24'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'd0;              // [7:0] data_byte
    logic        s_axis_tuser  = sfpb_pkg::OP_HOST; // [0] operation
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;                      // [7:0] payload
    logic [1:0]  m_axis_tuser;                      // [1:0] destination
    logic        m_axis_tlast;

    serial_flash_programmer_bridge #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // The limit is far above the slowest legal run: every query answer
    // waiting out the longest receiver stall, plus the long hold-off.
    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Shared bookkeeping between the stimulus, the driver and the monitor.
    // ------------------------------------------------------------------
    t_host_item items_to_send[$];    // filled by the stimulus, drained by the driver
    t_reply     expected_replies[$]; // what the block owes, oldest first
    t_reply     item_replies[$];     // replies caused by the item being predicted
    int         n_offered  = 0;
    int         n_accepted = 0;
    int         n_fail     = 0;
    logic       quiet      = 1'b0;  // no idling on either side once set
    logic       hold_armed = 1'b0;  // lets the receiver start its long stall

    // ------------------------------------------------------------------
    // Predictor: a copy of the command engine state and the registers.
    // ------------------------------------------------------------------
    t_bridge_phase ph;
    logic [7:0]    cmd_now;
    int            params_seen;
    int            params_needed;
    int            write_len;
    int            reads_owed;
    logic [15:0]   reg_version;
    logic [15:0]   reg_serbuf;
    logic [23:0]   reg_max_write;
    logic [23:0]   reg_max_read;
    logic [7:0]    reg_bus_flag;

    task automatic engine_reset();
        reg_version   = 16'd1;
        reg_serbuf    = 16'd16;
        reg_max_write = 24'd200;
        reg_max_read  = 24'd200;
        reg_bus_flag  = 8'd8;
        ph            = WAIT_CMD;
        cmd_now       = 8'd0;
        params_seen   = 0;
        params_needed = 0;
        write_len     = 0;
        reads_owed    = 0;
    endtask

    task automatic add_reply(input logic [1:0] dest, input logic [7:0] data);
        item_replies.push_back('{dest, data, 1'b0});
    endtask

    task automatic answer_query(input logic [7:0] cmd);
        case (cmd)
            sfpb_pkg::CMD_NOP: add_reply(sfpb_pkg::DEST_HOST, sfpb_pkg::ACK_BYTE);
            sfpb_pkg::CMD_Q_IFACE: begin
                add_reply(sfpb_pkg::DEST_HOST, sfpb_pkg::ACK_BYTE);
                add_reply(sfpb_pkg::DEST_HOST, reg_version[7:0]);
                add_reply(sfpb_pkg::DEST_HOST, reg_version[15:8]);
            end
            sfpb_pkg::CMD_Q_CMDMAP: begin
                // Supported-command bitmap: only the first three bytes
                // carry set bits.
                add_reply(sfpb_pkg::DEST_HOST, sfpb_pkg::ACK_BYTE);
                add_reply(sfpb_pkg::DEST_HOST, 8'h3F);
                add_reply(sfpb_pkg::DEST_HOST, 8'h01);
                add_reply(sfpb_pkg::DEST_HOST, 8'h0F);
                for (int i = 3; i < sfpb_pkg::MAP_LEN; i++) add_reply(sfpb_pkg::DEST_HOST, 8'h00);
            end
            sfpb_pkg::CMD_Q_PGMNAME: begin
                add_reply(sfpb_pkg::DEST_HOST, sfpb_pkg::ACK_BYTE);
                for (int i = 0; i < 16; i++) add_reply(sfpb_pkg::DEST_HOST, PGM_NAME[i]);
            end
            sfpb_pkg::CMD_Q_SERBUF: begin
                add_reply(sfpb_pkg::DEST_HOST, sfpb_pkg::ACK_BYTE);
                add_reply(sfpb_pkg::DEST_HOST, reg_serbuf[7:0]);
                add_reply(sfpb_pkg::DEST_HOST, reg_serbuf[15:8]);
            end
            sfpb_pkg::CMD_Q_BUSTYPE: begin
                add_reply(sfpb_pkg::DEST_HOST, sfpb_pkg::ACK_BYTE);
                add_reply(sfpb_pkg::DEST_HOST, reg_bus_flag);
            end
            sfpb_pkg::CMD_Q_WRNMAXLEN: begin
                add_reply(sfpb_pkg::DEST_HOST, sfpb_pkg::ACK_BYTE);
                add_reply(sfpb_pkg::DEST_HOST, reg_max_write[7:0]);
                add_reply(sfpb_pkg::DEST_HOST, reg_max_write[15:8]);
                add_reply(sfpb_pkg::DEST_HOST, reg_max_write[23:16]);
            end
            sfpb_pkg::CMD_SYNCNOP: begin
                add_reply(sfpb_pkg::DEST_HOST, sfpb_pkg::NAK_BYTE);
                add_reply(sfpb_pkg::DEST_HOST, sfpb_pkg::ACK_BYTE);
            end
            sfpb_pkg::CMD_Q_RDNMAXLEN: begin
                add_reply(sfpb_pkg::DEST_HOST, sfpb_pkg::ACK_BYTE);
                add_reply(sfpb_pkg::DEST_HOST, reg_max_read[7:0]);
                add_reply(sfpb_pkg::DEST_HOST, reg_max_read[15:8]);
                add_reply(sfpb_pkg::DEST_HOST, reg_max_read[23:16]);
            end
            default: add_reply(sfpb_pkg::DEST_HOST, sfpb_pkg::NAK_BYTE);
        endcase
    endtask

    // All write bytes are out: acknowledge, then either ask for the read
    // burst or drop chip select right away.
    task automatic close_writes();
        add_reply(sfpb_pkg::DEST_HOST, sfpb_pkg::ACK_BYTE);
        if (reads_owed != 0) begin
            add_reply(sfpb_pkg::DEST_READ_REQ, 8'(reads_owed));
            ph = WAIT_READS;
        end else begin
            add_reply(sfpb_pkg::DEST_CS, 8'd0);
            ph = WAIT_CMD;
        end
    endtask

    // Works out the replies one accepted item causes and queues them.
    task automatic predict_replies(input logic op, input logic [7:0] b);
        int sh;
        item_replies.delete();
        if (op == sfpb_pkg::OP_SPI) begin
            // A read-back byte only matters while a burst is outstanding.
            if (ph == WAIT_READS && reads_owed != 0) begin
                add_reply(sfpb_pkg::DEST_HOST, b);
                reads_owed--;
                if (reads_owed == 0) begin
                    add_reply(sfpb_pkg::DEST_CS, 8'd0);
                    ph = WAIT_CMD;
                end
            end
        end else if (ph == WAIT_READS) begin
            // Host bytes are dropped while the read burst is pending.
        end else if (ph == TAKE_PARAMS) begin
            params_seen++;
            if (cmd_now == sfpb_pkg::CMD_S_BUSTYPE) begin
                add_reply(sfpb_pkg::DEST_HOST,
                          (b == reg_bus_flag) ? sfpb_pkg::ACK_BYTE : sfpb_pkg::NAK_BYTE);
                ph = WAIT_CMD;
            end else if (params_seen <= sfpb_pkg::SPIOP_HDR) begin
                // Three write-length then three read-length bytes, little
                // endian; only the low LENGTH_BITS of each survive.
                sh = ((params_seen - 1) % 3) * 8;
                if (params_seen <= 3) write_len = (write_len | (int'(b) << sh)) & LEN_MASK;
                else                  reads_owed = (reads_owed | (int'(b) << sh)) & LEN_MASK;
                if (params_seen == 3) params_needed = sfpb_pkg::SPIOP_HDR + write_len;
                if (params_seen == sfpb_pkg::SPIOP_HDR) begin
                    add_reply(sfpb_pkg::DEST_CS, 8'd1);
                    if (params_needed == sfpb_pkg::SPIOP_HDR) close_writes();
                end
            end else begin
                add_reply(sfpb_pkg::DEST_SPI_WRITE, b);
                if (params_seen >= params_needed) close_writes();
            end
        end else begin
            cmd_now       = b;
            params_seen   = 0;
            params_needed = 0;
            ph            = WAIT_CMD;
            if (b == sfpb_pkg::CMD_S_BUSTYPE) begin
                params_needed = 1;
                ph            = TAKE_PARAMS;
            end else if (b == sfpb_pkg::CMD_O_SPIOP) begin
                params_needed = sfpb_pkg::SPIOP_HDR;
                write_len     = 0;
                reads_owed    = 0;
                ph            = TAKE_PARAMS;
            end else begin
                answer_query(b);
            end
        end
        if (item_replies.size() > 0) item_replies[item_replies.size() - 1].last = 1'b1;
        foreach (item_replies[i]) expected_replies.push_back(item_replies[i]);
    endtask

    // ------------------------------------------------------------------
    // Driver: offers queued items on the slave stream, with idle bursts.
    // ------------------------------------------------------------------
    int         send_gap = 0;
    t_host_item next_item;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_replies(s_axis_tuser, s_axis_tdata);
                n_accepted++;
            end
            // A new item may go out only once the current one is taken.
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 9) == 0) begin
                    send_gap = $urandom_range(1, 6) - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (items_to_send.size() > 0) begin
                    next_item = items_to_send.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= next_item.op;
                    s_axis_tdata  <= next_item.data;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Long hold-off: counted here, once armed, and seen by the receiver
    // as a flag.
    // ------------------------------------------------------------------
    int   hold_left = 0;
    logic hold_done = 1'b0;
    logic hold_on   = 1'b0;

    always @(posedge i_clk) begin
        if (hold_armed && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            hold_on <= 1'b1;
        end else begin
            hold_on <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each accepted result against the oldest expectation
    // and plays the receiver, including the long stall that fills the
    // block's reply queue while the driver keeps offering items.
    // ------------------------------------------------------------------
    int     stall_left = 0;
    t_reply want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_replies.size() == 0) begin
                    $error("unexpected result: destination %0d, payload 0x%02h, last %0b",
                           m_axis_tuser, m_axis_tdata, m_axis_tlast);
                    n_fail++;
                end else begin
                    want = expected_replies.pop_front();
                    if (m_axis_tuser !== want.dest) begin
                        $error("destination: expected %0d, actual %0d",
                               want.dest, m_axis_tuser);
                        n_fail++;
                    end
                    if (m_axis_tdata !== want.data) begin
                        $error("payload: expected 0x%02h, actual 0x%02h",
                               want.data, m_axis_tdata);
                        n_fail++;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $error("last: expected %0b, actual %0b", want.last, m_axis_tlast);
                        n_fail++;
                    end
                end
            end
            if (hold_on) begin
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 6) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    task automatic send(input logic op, input logic [7:0] b);
        items_to_send.push_back('{op, b});
        n_offered++;
    endtask

    task automatic send_queries();
        foreach (QUERY_CMDS[i]) send(sfpb_pkg::OP_HOST, QUERY_CMDS[i]);
    endtask

    // One complete SPI transfer: header, write bytes, then the read-back
    // bytes, with stray host bytes mixed in among the reads now and then.
    task automatic spi_transfer(input logic [7:0] wlen, input logic [7:0] rlen,
                                input logic [7:0] hi, input int noise_pct);
        send(sfpb_pkg::OP_HOST, sfpb_pkg::CMD_O_SPIOP);
        send(sfpb_pkg::OP_HOST, wlen);
        send(sfpb_pkg::OP_HOST, hi);
        send(sfpb_pkg::OP_HOST, hi);
        send(sfpb_pkg::OP_HOST, rlen);
        send(sfpb_pkg::OP_HOST, hi);
        send(sfpb_pkg::OP_HOST, hi);
        for (int i = 0; i < wlen; i++) send(sfpb_pkg::OP_HOST, 8'($urandom_range(0, 255)));
        for (int i = 0; i < rlen; i++) begin
            if ($urandom_range(1, 100) <= noise_pct) begin
                send(sfpb_pkg::OP_HOST, 8'($urandom_range(0, 255)));
            end
            send(sfpb_pkg::OP_SPI, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic random_traffic(input int n_items);
        int         stop_at;
        int         pick;
        logic [7:0] c;
        stop_at = n_offered + n_items;
        while (n_offered < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                send(sfpb_pkg::OP_HOST, QUERY_CMDS[$urandom_range(0, 8)]);
            end else if (pick < 42) begin
                send(sfpb_pkg::OP_HOST, sfpb_pkg::CMD_S_BUSTYPE);
                send(sfpb_pkg::OP_HOST,
                     $urandom_range(0, 1) ? reg_bus_flag : 8'($urandom_range(0, 255)));
            end else if (pick < 80) begin
                // Mostly short transfers; now and then a longer one.
                if ($urandom_range(0, 19) == 0)
                    spi_transfer(8'($urandom_range(0, 40)), 8'($urandom_range(0, 40)),
                                 8'($urandom_range(0, 255)), 10);
                else
                    spi_transfer(8'($urandom_range(0, 6)), 8'($urandom_range(0, 6)),
                                 8'($urandom_range(0, 255)), 10);
            end else if (pick < 92) begin
                do c = 8'($urandom_range(0, 255));
                while (c inside {QUERY_CMDS, sfpb_pkg::CMD_S_BUSTYPE, sfpb_pkg::CMD_O_SPIOP});
                send(sfpb_pkg::OP_HOST, c);
            end else begin
                // Read-back byte with no burst pending: dropped by the block.
                send(sfpb_pkg::OP_SPI, 8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Waits until every item is taken and every reply has come back, then
    // gives the block time to finish items that produce nothing.
    task automatic drain();
        while (n_accepted != n_offered || expected_replies.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes one register; the model follows at once since the block is idle.
    task automatic write_reg(input logic [2:0] idx, input logic [23:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        case (idx)
            sfpb_pkg::CFG_IFACE_VERSION: reg_version   = value[15:0];
            sfpb_pkg::CFG_SERIAL_BUF:    reg_serbuf    = value[15:0];
            sfpb_pkg::CFG_MAX_WRITE:     reg_max_write = value;
            sfpb_pkg::CFG_MAX_READ:      reg_max_read  = value;
            sfpb_pkg::CFG_BUS_FLAG:      reg_bus_flag  = value[7:0];
            default: ;
        endcase
    endtask

    task automatic write_all_regs(input logic [23:0] v16a, input logic [23:0] v16b,
                                  input logic [23:0] v24a, input logic [23:0] v24b,
                                  input logic [23:0] v8);
        write_reg(sfpb_pkg::CFG_IFACE_VERSION, v16a);
        write_reg(sfpb_pkg::CFG_SERIAL_BUF, v16b);
        write_reg(sfpb_pkg::CFG_MAX_WRITE, v24a);
        write_reg(sfpb_pkg::CFG_MAX_READ, v24b);
        write_reg(sfpb_pkg::CFG_BUS_FLAG, v8);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    initial begin
        engine_reset();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part with the reset register values: every query, an
        // unknown command, set-bustype accepted and refused, a stray
        // read-back byte, a transfer with no data at all, and a transfer
        // whose high length bytes are all ones (they must be ignored) with
        // a host byte arriving while the read is pending.
        send_queries();
        send(sfpb_pkg::OP_HOST, 8'hFF);
        send(sfpb_pkg::OP_HOST, sfpb_pkg::CMD_S_BUSTYPE);
        send(sfpb_pkg::OP_HOST, reg_bus_flag);
        send(sfpb_pkg::OP_HOST, sfpb_pkg::CMD_S_BUSTYPE);
        send(sfpb_pkg::OP_HOST, 8'h00);
        send(sfpb_pkg::OP_SPI, 8'hFF);
        spi_transfer(8'd0, 8'd0, 8'h00, 0);
        spi_transfer(8'd1, 8'd1, 8'hFF, 100);
        drain();

        // All registers at their largest values; the receiver holds off
        // once for a long stretch in this phase.
        write_all_regs(24'hFFFF, 24'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFF);
        hold_armed = 1'b1;
        send_queries();
        random_traffic(80);
        drain();

        // All registers at zero.
        write_all_regs(24'h0, 24'h0, 24'h0, 24'h0, 24'h0);
        send_queries();
        random_traffic(80);
        drain();

        // Random register values and no idling.
        write_all_regs(24'($urandom_range(0, 16'hFFFF)), 24'($urandom_range(0, 16'hFFFF)),
                       24'($urandom_range(0, 24'hFFFFFF)), 24'($urandom_range(0, 24'hFFFFFF)),
                       24'($urandom_range(0, 8'hFF)));
        quiet = 1'b1;
        send_queries();
        random_traffic(80);
        drain();

        if (n_fail == 0 && expected_replies.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- serial_flash_programmer_bridge.f -----
rtl/sfpb_pkg.sv
rtl/sfpb_decode.sv
rtl/sfpb_queue.sv
rtl/sfpb_emit.sv
rtl/serial_flash_programmer_bridge.sv
dv/tb.sv
